/* rtl/bgrl_pkg.sv */
// Package for the binary grid run-length block: field widths, register indexes,
// result kind codes and the result record.
// No dependencies; imported by rtl/binary_grid_run_lengths.sv.
package bgrl_pkg;

    localparam int MAX_WIDTH_DEF  = 64;
    localparam int MAX_HEIGHT_DEF = 64;

    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int KIND_W     = 2;
    localparam int LINE_W     = 6;
    localparam int RUN_W      = 7;

    localparam logic [RUN_W-1:0]      RUN_CAP         = 7'd127;
    localparam logic [CFG_DATA_W-1:0] GRID_SIZE_RESET = 7'd64;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'd1;

    typedef enum logic [KIND_W-1:0] {
        KIND_ROW_RUN = 2'd0,
        KIND_COL_RUN = 2'd1,
        KIND_ROW_END = 2'd2,
        KIND_COL_END = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [LINE_W-1:0] line_index;
        logic [RUN_W-1:0]  run_length;
    } result_t;

    // Saturating increment of a run counter.
    function automatic logic [RUN_W-1:0] run_bump(input logic [RUN_W-1:0] v);
        run_bump = (v < RUN_CAP) ? v + 7'd1 : RUN_CAP;
    endfunction

endpackage

/* rtl/binary_grid_run_lengths.sv */
// Path: an accepted pixel is registered in stage 1 and then in the result bundle
// register. Throughput: one pixel per cycle while each pixel gives at most one result
// and result_stall is low; a pixel that gives several results (up to four) holds the
// single output port until all are taken. Reset: asynchronous and active low; afterwards
// a clearing pass zeroes the column run memory while the pixel channel is stalled.
//
// Top level of the binary grid run-length encoder; depends on rtl/bgrl_pkg.sv.
module binary_grid_run_lengths #(
    parameter int MAX_WIDTH  = bgrl_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bgrl_pkg::MAX_HEIGHT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Configuration write port.
    input  logic                           cfg_wen,
    input  logic [bgrl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bgrl_pkg::CFG_DATA_W-1:0] cfg_data,
    // Pixel channel.
    input  logic                           pixel_valid,
    output logic                           pixel_stall,
    input  logic                           pixel,
    // Result channel.
    output logic                           result_valid,
    input  logic                           result_stall,
    output logic [bgrl_pkg::KIND_W-1:0]    kind,
    output logic [bgrl_pkg::LINE_W-1:0]    line_index,
    output logic [bgrl_pkg::RUN_W-1:0]     run_length,
    output logic                           last_of_item
);
    import bgrl_pkg::*;

    // Position counters need just enough bits for the largest grid. Size compares
    // are made at a width that holds both the 7-bit registers and the maxima.
    localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int SZ_WC  = $clog2(MAX_WIDTH + 1);
    localparam int SZ_WR  = $clog2(MAX_HEIGHT + 1);
    localparam int SZ_W0  = (SZ_WC > SZ_WR) ? SZ_WC : SZ_WR;
    localparam int SZ_W   = (SZ_W0 > CFG_DATA_W) ? SZ_W0 : CFG_DATA_W;
    localparam logic [SZ_W-1:0]  MAX_W_SZ  = SZ_W'(MAX_WIDTH);
    localparam logic [SZ_W-1:0]  MAX_H_SZ  = SZ_W'(MAX_HEIGHT);
    localparam logic [COL_W-1:0] LAST_ADDR = COL_W'(MAX_WIDTH - 1);

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [CFG_DATA_W-1:0] grid_width_reg;
    logic [CFG_DATA_W-1:0] grid_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= GRID_SIZE_RESET;
            grid_height_reg <= GRID_SIZE_RESET;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                REG_GRID_WIDTH:  grid_width_reg  <= cfg_data;
                REG_GRID_HEIGHT: grid_height_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Effective sizes: zero acts as one, and anything above the maximum is clamped.
    logic [SZ_W-1:0] width_raw;
    logic [SZ_W-1:0] height_raw;
    logic [SZ_W-1:0] width_eff;
    logic [SZ_W-1:0] height_eff;

    always_comb
    begin
        width_raw  = SZ_W'(grid_width_reg);
        height_raw = SZ_W'(grid_height_reg);
        if (width_raw == '0)
            width_eff = SZ_W'(1);
        else if (width_raw > MAX_W_SZ)
            width_eff = MAX_W_SZ;
        else
            width_eff = width_raw;
        if (height_raw == '0)
            height_eff = SZ_W'(1);
        else if (height_raw > MAX_H_SZ)
            height_eff = MAX_H_SZ;
        else
            height_eff = height_raw;
    end

    // ------------------------------------------------------------------
    // Column run memory and its clearing pass after reset.
    // ------------------------------------------------------------------
    logic [RUN_W-1:0] col_mem [MAX_WIDTH];
    logic [RUN_W-1:0] mem_q_reg;
    logic             mem_we;
    logic [COL_W-1:0] mem_waddr;
    logic [RUN_W-1:0] mem_wdata;

    logic             clr_busy_reg;
    logic             clr_busy_next;
    logic [COL_W-1:0] clr_addr_reg;
    logic [COL_W-1:0] clr_addr_next;

    // ------------------------------------------------------------------
    // Stage 0: raster position, row run and pixel acceptance.
    // ------------------------------------------------------------------
    logic [COL_W-1:0] col_pos_reg;
    logic [COL_W-1:0] col_pos_next;
    logic [ROW_W-1:0] row_pos_reg;
    logic [ROW_W-1:0] row_pos_next;
    logic [RUN_W-1:0] row_run_reg;
    logic [RUN_W-1:0] row_run_next;
    logic [RUN_W-1:0] row_bumped;
    logic             last_col;
    logic             last_row;
    logic             row_run_en;
    logic [RUN_W-1:0] row_run_len;
    logic             in_acc;

    // Stage 1: the column counter is read back from memory here.
    logic             s1_valid_reg;
    logic             s1_valid_next;
    logic             s1_set_reg;
    logic             s1_last_row_reg;
    logic             s1_last_col_reg;
    logic             s1_row_run_en_reg;
    logic [RUN_W-1:0] s1_row_run_len_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic             s1_fwd_reg;
    logic [RUN_W-1:0] s1_fwd_val_reg;
    logic             s1_go;
    logic [RUN_W-1:0] col_old;
    logic [RUN_W-1:0] col_bumped;
    logic [RUN_W-1:0] col_wr_val;
    logic             col_run_en;
    logic [RUN_W-1:0] col_run_len;
    result_t          cand     [4];
    logic [3:0]       cand_en;
    result_t          s1_res   [4];
    logic [2:0]       s1_cnt;

    // Result bundle: the output register, holding every result of one pixel.
    result_t          bund_res_reg [4];
    logic             bund_valid_reg;
    logic             bund_valid_next;
    logic [2:0]       bund_cnt_reg;
    logic [1:0]       bund_idx_reg;
    logic [1:0]       bund_idx_next;
    logic             bund_last;
    logic             bund_free;
    logic             out_take;
    logic             bund_load;

    always_comb
    begin
        last_col   = SZ_W'(col_pos_reg) >= (width_eff - SZ_W'(1));
        last_row   = SZ_W'(row_pos_reg) >= (height_eff - SZ_W'(1));
        row_bumped = run_bump(row_run_reg);

        // A set pixel reports its grown run only at the row's end; a clear pixel
        // closes any open run.
        if (pixel)
        begin
            row_run_en  = last_col;
            row_run_len = row_bumped;
        end
        else
        begin
            row_run_en  = (row_run_reg != '0);
            row_run_len = row_run_reg;
        end
        row_run_next = (pixel && !last_col) ? row_bumped : '0;

        if (last_col)
        begin
            col_pos_next = '0;
            row_pos_next = last_row ? '0 : row_pos_reg + ROW_W'(1);
        end
        else
        begin
            col_pos_next = col_pos_reg + COL_W'(1);
            row_pos_next = row_pos_reg;
        end
    end

    // Output side.
    assign result_valid = bund_valid_reg;
    assign out_take     = bund_valid_reg && !result_stall;
    assign bund_last    = (3'(bund_idx_reg) + 3'd1) == bund_cnt_reg;
    assign bund_free    = !bund_valid_reg || (out_take && bund_last);
    assign kind         = bund_res_reg[bund_idx_reg].kind;
    assign line_index   = bund_res_reg[bund_idx_reg].line_index;
    assign run_length   = bund_res_reg[bund_idx_reg].run_length;
    assign last_of_item = bund_last;

    // Stage 1: finish the column direction and collect the results in order.
    always_comb
    begin
        col_old    = s1_fwd_reg ? s1_fwd_val_reg : mem_q_reg;
        col_bumped = run_bump(col_old);
        if (s1_set_reg)
        begin
            col_run_en  = s1_last_row_reg;
            col_run_len = col_bumped;
        end
        else
        begin
            col_run_en  = (col_old != '0);
            col_run_len = col_old;
        end
        col_wr_val = (s1_set_reg && !s1_last_row_reg) ? col_bumped : '0;

        cand[0] = '{kind: KIND_ROW_RUN, line_index: LINE_W'(s1_row_reg),
                    run_length: s1_row_run_len_reg};
        cand[1] = '{kind: KIND_ROW_END, line_index: LINE_W'(s1_row_reg),
                    run_length: '0};
        cand[2] = '{kind: KIND_COL_RUN, line_index: LINE_W'(s1_col_reg),
                    run_length: col_run_len};
        cand[3] = '{kind: KIND_COL_END, line_index: LINE_W'(s1_col_reg),
                    run_length: '0};
        cand_en = {s1_last_row_reg, col_run_en, s1_last_col_reg, s1_row_run_en_reg};

        for (int i = 0; i < 4; i++)
            s1_res[i] = cand[3];
        s1_cnt = '0;
        for (int i = 0; i < 4; i++)
        begin
            if (cand_en[i])
            begin
                s1_res[s1_cnt[1:0]] = cand[i];
                s1_cnt = s1_cnt + 3'd1;
            end
        end

        // A pixel with no results retires without waiting for the output.
        s1_go         = s1_valid_reg && ((s1_cnt == '0) || bund_free);
        pixel_stall   = clr_busy_reg || (s1_valid_reg && !s1_go);
        in_acc        = pixel_valid && !pixel_stall;
        s1_valid_next = in_acc || (s1_valid_reg && !s1_go);

        bund_load = s1_go && (s1_cnt != '0);
        if (bund_load)
        begin
            bund_valid_next = 1'b1;
            bund_idx_next   = '0;
        end
        else if (out_take)
        begin
            bund_valid_next = !bund_last;
            bund_idx_next   = bund_idx_reg + 2'd1;
        end
        else
        begin
            bund_valid_next = bund_valid_reg;
            bund_idx_next   = bund_idx_reg;
        end

        // The clearing pass owns the write port until it is done; no pixel is in
        // flight while it runs.
        if (clr_busy_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = s1_go;
            mem_waddr = s1_col_reg;
            mem_wdata = col_wr_val;
        end
        clr_busy_next = clr_busy_reg && (clr_addr_reg != LAST_ADDR);
        clr_addr_next = clr_busy_reg ? clr_addr_reg + COL_W'(1) : clr_addr_reg;
    end

    // The memory is read only when a pixel is accepted, so the word stays put
    // while stage 1 waits on the output.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            col_mem[mem_waddr] <= mem_wdata;
        if (in_acc)
            mem_q_reg <= col_mem[col_pos_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg   <= 1'b1;
            clr_addr_reg   <= '0;
            col_pos_reg    <= '0;
            row_pos_reg    <= '0;
            row_run_reg    <= '0;
            s1_valid_reg   <= 1'b0;
            bund_valid_reg <= 1'b0;
            bund_idx_reg   <= '0;
        end
        else
        begin
            clr_busy_reg   <= clr_busy_next;
            clr_addr_reg   <= clr_addr_next;
            s1_valid_reg   <= s1_valid_next;
            bund_valid_reg <= bund_valid_next;
            bund_idx_reg   <= bund_idx_next;
            if (in_acc)
            begin
                col_pos_reg <= col_pos_next;
                row_pos_reg <= row_pos_next;
                row_run_reg <= row_run_next;
            end
        end
    end

    // Payload registers of stage 1 and of the bundle.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_set_reg         <= pixel;
            s1_last_row_reg    <= last_row;
            s1_last_col_reg    <= last_col;
            s1_row_run_en_reg  <= row_run_en;
            s1_row_run_len_reg <= row_run_len;
            s1_col_reg         <= col_pos_reg;
            s1_row_reg         <= row_pos_reg;
            // On a one-column grid the retiring pixel writes the same word in the
            // same edge as this read, so its value is forwarded instead.
            s1_fwd_reg         <= s1_go && (s1_col_reg == col_pos_reg);
            s1_fwd_val_reg     <= col_wr_val;
        end
        if (bund_load)
        begin
            bund_res_reg <= s1_res;
            bund_cnt_reg <= s1_cnt;
        end
    end

`ifndef ASSERT_OFF
    // A loaded bundle always holds at least one result and the read index stays inside it.
    a_bundle_index: assert property (@(posedge clk) disable iff (!rst_n)
        bund_valid_reg |-> (bund_cnt_reg != 3'd0) && (3'(bund_idx_reg) < bund_cnt_reg))
        else $error("result bundle index outside its count");

    // A pixel reading the word being written back must take the forwarded value.
    a_forward: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && s1_go && (s1_col_reg == col_pos_reg)) |=> s1_fwd_reg)
        else $error("missing forward on column memory hazard");

    // No pixel enters while the column memory is still being cleared.
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !in_acc && !s1_valid_reg)
        else $error("pixel in flight during clearing pass");
`endif

endmodule
